// ===== rtl/bmpd_pkg.sv =====
// Shared types and constants for the BMP stream decoder.
`timescale 1ns / 1ps
`default_nettype none
package bmpd_pkg;

	localparam int DEF_MAX_WIDTH   = 4096;
	localparam int DEF_MAX_HEIGHT  = 4096;
	localparam int DEF_MAX_PALETTE = 256;

	localparam logic [2:0] KIND_INFO    = 3'd0;
	localparam logic [2:0] KIND_PALETTE = 3'd1;
	localparam logic [2:0] KIND_INDEXED = 3'd2;
	localparam logic [2:0] KIND_COLOUR  = 3'd3;
	localparam logic [2:0] KIND_ERROR   = 3'd4;

	localparam logic [2:0] ERR_SIGNATURE = 3'd0;
	localparam logic [2:0] ERR_DEPTH     = 3'd1;
	localparam logic [2:0] ERR_SIZE      = 3'd2;
	localparam logic [2:0] ERR_PALETTE   = 3'd3;
	localparam logic [2:0] ERR_TRUNCATED = 3'd4;

	localparam logic [7:0] SIG_B = 8'h42;
	localparam logic [7:0] SIG_M = 8'h4D;

	// One classified byte: a burst of up to eight results sharing most fields.
	// For a packed burst (depth 1 or 4) the back end expands pixel indexes.
	typedef struct packed {
		logic [2:0]  kind;
		logic [12:0] x;
		logic [12:0] y;
		logic [7:0]  index;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [2:0]  error_code;
		logic [3:0]  count;      // results in this burst, 0 for none
		logic [1:0]  shift;      // 0 single, 1 for 1-bit unpack, 2 for 4-bit unpack
		logic [7:0]  packed_byte;
		logic        done_on_last;
	} burst_t;

endpackage
`default_nettype wire

// ===== rtl/bmp_stream_decoder_top.sv =====
// Top level of the BMP stream decoder.
`timescale 1ns / 1ps
`default_nettype none
// Decodes an uncompressed BMP file fed one byte per transaction and emits info, palette,
// pixel and error results. One byte is accepted per cycle while the queue has room; the front end parses and
// classifies each byte into a burst of up to eight results, a two-entry queue decouples it
// from the back end, which sends one result per cycle unless the result port stalls. A 1-bit
// byte thus expands to up to eight results and a 4-bit byte to up to two, so the sustained
// byte rate is set by the result port.
module bmp_stream_decoder_top
	import bmpd_pkg::*;
#(
	parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
	parameter int MAX_PALETTE = DEF_MAX_PALETTE
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_stream,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       kind,
	output logic [12:0]      x,
	output logic [12:0]      y,
	output logic [7:0]       index,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue,
	output logic [2:0]       error_code,
	output logic             image_done,
	output logic             last
);

	logic   f_valid, f_ready, q_valid, q_ready;
	burst_t f_burst, q_burst;

	bmpd_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
		.MAX_PALETTE(MAX_PALETTE)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .data_byte, .end_of_stream,
		.burst_valid(f_valid), .burst_ready(f_ready), .burst(f_burst));

	bmpd_queue u_queue (
		.clk, .arst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_burst),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_burst));

	bmpd_back u_back (
		.clk, .arst_n, .burst_valid(q_valid), .burst_ready(q_ready), .burst(q_burst),
		.out_valid, .out_ready, .kind, .x, .y, .index, .red, .green, .blue,
		.error_code, .image_done, .last);

endmodule
`default_nettype wire

// ===== rtl/bmpd_front.sv =====
// Front end: parses headers, tracks position and classifies each byte into a burst.
`timescale 1ns / 1ps
`default_nettype none
module bmpd_front
	import bmpd_pkg::*;
#(
	parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
	parameter int MAX_PALETTE = DEF_MAX_PALETTE
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       end_of_stream,
	output logic            burst_valid,
	input  wire logic       burst_ready,
	output burst_t          burst
);

	localparam logic [2:0] PH_HEADER  = 3'd0;
	localparam logic [2:0] PH_PALETTE = 3'd2;
	localparam logic [2:0] PH_PIXELS  = 3'd3;
	localparam logic [2:0] PH_DONE    = 3'd4;
	localparam logic [2:0] PH_ERROR   = 3'd5;

	logic [2:0]  phase_q;
	logic [5:0]  hdr_cnt_q;
	logic [31:0] shift_q;
	logic [13:0] width_q, height_q;
	logic [5:0]  depth_q;
	logic [8:0]  pal_cnt_q, pal_done_q;
	logic [13:0] col_q;
	logic [12:0] row_q;
	logic [15:0] rbc_q;
	logic [1:0]  sub_q;
	logic [23:0] part_q;
	logic [15:0] stride_q;

	logic [2:0]  phase_d;
	logic [5:0]  hdr_cnt_d;
	logic [31:0] shift_d;
	logic [13:0] width_d, height_d;
	logic [5:0]  depth_d;
	logic [8:0]  pal_cnt_d, pal_done_d;
	logic [13:0] col_d;
	logic [12:0] row_d;
	logic [15:0] rbc_d;
	logic [1:0]  sub_d;
	logic [23:0] part_d;
	logic [15:0] stride_d;
	burst_t      b;

	logic        take;
	logic [31:0] fs;
	logic [15:0] dhi;
	logic [13:0] remain;
	logic [3:0]  npix;
	logic [3:0]  maxp;
	logic [9:0]  pal_eff;
	logic        last_pix;
	logic [16:0] bytes_w;

	assign in_ready = burst_ready;
	assign take = in_valid && in_ready;
	assign fs = {data_byte, shift_q[31:8]};
	assign dhi = fs[31:16];
	assign remain = width_q - col_q;

	always_comb begin
		phase_d = phase_q; hdr_cnt_d = hdr_cnt_q; shift_d = shift_q;
		width_d = width_q; height_d = height_q; depth_d = depth_q;
		pal_cnt_d = pal_cnt_q; pal_done_d = pal_done_q; col_d = col_q;
		row_d = row_q; rbc_d = rbc_q; sub_d = sub_q; part_d = part_q;
		stride_d = stride_q;
		b = '0;
		npix = '0; maxp = '0; pal_eff = '0; last_pix = 1'b0; bytes_w = '0;
		case (phase_q)
			PH_HEADER: begin
				if ((hdr_cnt_q == 6'd0 && data_byte != SIG_B) ||
						(hdr_cnt_q == 6'd1 && data_byte != SIG_M)) begin
					b.kind = KIND_ERROR; b.error_code = ERR_SIGNATURE; b.count = 4'd1;
					phase_d = PH_ERROR;
				end else begin
					shift_d = fs;
					if (hdr_cnt_q == 6'd21)
						width_d = (fs >= 32'd1 && fs <= 32'(MAX_WIDTH)) ? fs[13:0] : '0;
					if (hdr_cnt_q == 6'd25)
						height_d = (fs >= 32'd1 && fs <= 32'(MAX_HEIGHT)) ? fs[13:0] : '0;
					if (hdr_cnt_q == 6'd29)
						depth_d = (dhi == 16'd1 || dhi == 16'd4 || dhi == 16'd8 ||
							dhi == 16'd24 || dhi == 16'd32) ? dhi[5:0] : '0;
					if (hdr_cnt_q == 6'd49)
						pal_cnt_d = (fs > 32'd511) ? 9'd511 : fs[8:0];
					if (hdr_cnt_q < 6'd53) begin
						hdr_cnt_d = hdr_cnt_q + 6'd1;
					end else begin
						b.count = 4'd1;
						if (depth_q == 6'd0) begin
							b.kind = KIND_ERROR; b.error_code = ERR_DEPTH; phase_d = PH_ERROR;
						end else if (width_q == 14'd0 || height_q == 14'd0) begin
							b.kind = KIND_ERROR; b.error_code = ERR_SIZE; phase_d = PH_ERROR;
						end else begin
							if (depth_q <= 6'd8) begin
								pal_eff = (pal_cnt_q == 9'd0) ?
									(10'd1 << depth_q[3:0]) : {1'b0, pal_cnt_q};
							end
							if (depth_q <= 6'd8 && pal_eff > 10'(MAX_PALETTE)) begin
								b.kind = KIND_ERROR; b.error_code = ERR_PALETTE;
								phase_d = PH_ERROR;
							end else begin
								pal_cnt_d = pal_eff[8:0];
								// a width or height of 8192 reports as 0 in the 13-bit field
								b.kind = KIND_INFO; b.x = width_q[12:0]; b.y = height_q[12:0];
								b.index = {2'b0, depth_q};
								row_d = height_q[12:0] - 13'd1;
								phase_d = (pal_eff != 10'd0) ? PH_PALETTE : PH_PIXELS;
								case (depth_q)
									6'd1:  bytes_w = (17'(width_q) + 17'd7) >> 3;
									6'd4:  bytes_w = (17'(width_q) + 17'd1) >> 1;
									6'd8:  bytes_w = 17'(width_q);
									6'd24: bytes_w = 17'(width_q) * 17'd3;
									default: bytes_w = 17'(width_q) << 2;
								endcase
								bytes_w = (bytes_w + 17'd3) & ~17'd3;
								stride_d = bytes_w[15:0];
							end
						end
					end
				end
			end
			PH_PALETTE: begin
				if (sub_q < 2'd3) begin
					case (sub_q)
						2'd0: part_d[7:0] = data_byte;
						2'd1: part_d[15:8] = data_byte;
						default: part_d[23:16] = data_byte;
					endcase
					sub_d = sub_q + 2'd1;
				end else begin
					sub_d = '0;
					b.kind = KIND_PALETTE; b.index = pal_done_q[7:0]; b.count = 4'd1;
					b.red = part_q[23:16]; b.green = part_q[15:8]; b.blue = part_q[7:0];
					pal_done_d = pal_done_q + 9'd1;
					if (pal_done_d >= pal_cnt_q) phase_d = PH_PIXELS;
				end
			end
			PH_PIXELS: begin
				b.x = col_q[12:0]; b.y = row_q;
				if (sub_q == 2'd3) begin
					sub_d = '0;
				end else if (col_q < width_q) begin
					case (depth_q)
						6'd1, 6'd4, 6'd8: begin
							maxp = (depth_q == 6'd1) ? 4'd8 : (depth_q == 6'd4) ? 4'd2 : 4'd1;
							npix = (remain < 14'(maxp)) ? remain[3:0] : maxp;
							b.kind = KIND_INDEXED; b.count = npix;
							b.shift = (depth_q == 6'd1) ? 2'd1 : (depth_q == 6'd4) ? 2'd2 : 2'd0;
							b.packed_byte = data_byte;
							b.index = (depth_q == 6'd1) ? {7'd0, data_byte[7]} :
								(depth_q == 6'd4) ? {4'd0, data_byte[7:4]} : data_byte;
							last_pix = 1'b1;
						end
						default: begin
							if (sub_q == 2'd0) begin
								part_d[7:0] = data_byte; sub_d = 2'd1;
							end else if (sub_q == 2'd1) begin
								part_d[15:8] = data_byte; sub_d = 2'd2;
							end else begin
								b.kind = KIND_COLOUR; b.count = 4'd1; npix = 4'd1;
								b.red = data_byte; b.green = part_q[15:8]; b.blue = part_q[7:0];
								sub_d = (depth_q == 6'd32) ? 2'd3 : 2'd0;
								last_pix = 1'b1;
							end
						end
					endcase
					if (last_pix) begin
						col_d = col_q + 14'(npix);
						if (col_d == width_q && row_q == 13'd0) begin
							b.done_on_last = 1'b1; phase_d = PH_DONE;
						end
					end
				end
				rbc_d = rbc_q + 16'd1;
				if (rbc_d >= stride_q) begin
					rbc_d = '0; col_d = '0;
					if (row_q != 13'd0) row_d = row_q - 13'd1;
				end
			end
			default: ;
		endcase
		if (end_of_stream) begin
			if (phase_d != PH_DONE && phase_d != PH_ERROR) begin
				b = '0; b.kind = KIND_ERROR; b.error_code = ERR_TRUNCATED; b.count = 4'd1;
			end
			phase_d = PH_HEADER; hdr_cnt_d = '0; shift_d = '0; width_d = '0;
			height_d = '0; depth_d = '0; pal_cnt_d = '0; pal_done_d = '0; col_d = '0;
			row_d = '0; rbc_d = '0; sub_d = '0; part_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER; hdr_cnt_q <= '0; shift_q <= '0; width_q <= '0;
			height_q <= '0; depth_q <= '0; pal_cnt_q <= '0; pal_done_q <= '0;
			col_q <= '0; row_q <= '0; rbc_q <= '0; sub_q <= '0; part_q <= '0;
			stride_q <= '0; burst_valid <= 1'b0; burst <= '0;
		end else begin
			if (take) begin
				phase_q <= phase_d; hdr_cnt_q <= hdr_cnt_d; shift_q <= shift_d;
				width_q <= width_d; height_q <= height_d; depth_q <= depth_d;
				pal_cnt_q <= pal_cnt_d; pal_done_q <= pal_done_d; col_q <= col_d;
				row_q <= row_d; rbc_q <= rbc_d; sub_q <= sub_d; part_q <= part_d;
				stride_q <= stride_d;
				burst <= b;
			end
			burst_valid <= take ? (b.count != 4'd0) : (burst_valid && !burst_ready);
		end
	end

endmodule
`default_nettype wire

// ===== rtl/bmpd_queue.sv =====
// Two-entry queue of bursts between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module bmpd_queue
	import bmpd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_valid,
	output logic      wr_ready,
	input  burst_t    wr_data,
	output logic      rd_valid,
	input  wire logic rd_ready,
	output burst_t    rd_data
);

	burst_t     mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] fill_q;
	logic       push, pop;

	assign wr_ready = (fill_q != 2'd2);
	assign rd_valid = (fill_q != 2'd0);
	assign rd_data = mem_q[rd_ptr_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0; rd_ptr_q <= 1'b0; fill_q <= '0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q == 2'd2 |-> !push) else $error("queue overflow");
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != 2'd3) else $error("queue fill out of range");
	a_fill_track: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> fill_q == $past(fill_q) + 2'd1) else $error("fill mismatch");
`endif

endmodule
`default_nettype wire

// ===== rtl/bmpd_back.sv =====
// Back end: expands each burst into result transactions.
`timescale 1ns / 1ps
`default_nettype none
module bmpd_back
	import bmpd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        burst_valid,
	output logic             burst_ready,
	input  burst_t           burst,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       kind,
	output logic [12:0]      x,
	output logic [12:0]      y,
	output logic [7:0]       index,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue,
	output logic [2:0]       error_code,
	output logic             image_done,
	output logic             last
);

	logic [2:0] pos_q;
	logic       is_last, fire;

	assign is_last = ({1'b0, pos_q} + 4'd1 == burst.count);
	assign fire = burst_valid && (!out_valid || out_ready);
	assign burst_ready = fire && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; out_valid <= 1'b0;
			kind <= '0; x <= '0; y <= '0; index <= '0; red <= '0; green <= '0;
			blue <= '0; error_code <= '0; image_done <= 1'b0; last <= 1'b0;
		end else begin
			out_valid <= fire || (out_valid && !out_ready);
			if (fire) begin
				pos_q <= is_last ? 3'd0 : pos_q + 3'd1;
				kind <= burst.kind; y <= burst.y; red <= burst.red;
				green <= burst.green; blue <= burst.blue; error_code <= burst.error_code;
				x <= burst.x + 13'(pos_q);
				case (burst.shift)
					2'd1: index <= {7'd0, burst.packed_byte[3'd7 - pos_q]};
					2'd2: index <= pos_q[0] ? {4'd0, burst.packed_byte[3:0]} :
						{4'd0, burst.packed_byte[7:4]};
					default: index <= burst.index;
				endcase
				image_done <= is_last && burst.done_on_last;
				last <= is_last;
			end
		end
	end

`ifndef SYNTHESIS
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		burst_valid |-> {1'b0, pos_q} < burst.count) else $error("position past burst");
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && image_done |-> last) else $error("image_done without last");
`endif

endmodule
`default_nettype wire

// ===== bench/bmp_decoder_checker.sv =====
// Result predictor and scoreboard for the BMP stream decoder bench.
`timescale 1ns / 1ps
module bmp_decoder_checker
	import bmpd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_stream,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [2:0]  kind,
	input  wire logic [12:0] x,
	input  wire logic [12:0] y,
	input  wire logic [7:0]  index,
	input  wire logic [7:0]  red,
	input  wire logic [7:0]  green,
	input  wire logic [7:0]  blue,
	input  wire logic [2:0]  error_code,
	input  wire logic        image_done,
	input  wire logic        last,
	output int               mismatches,
	output int               pending,
	output int               checked
);

	typedef enum logic [2:0] {
		ST_HEADER  = 3'd0,
		ST_PALETTE = 3'd2,
		ST_PIXELS  = 3'd3,
		ST_DONE    = 3'd4,
		ST_ERROR   = 3'd5
	} dec_state_e;

	typedef struct packed {
		logic [2:0]  kind;
		logic [12:0] x;
		logic [12:0] y;
		logic [7:0]  index;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [2:0]  error_code;
		logic        image_done;
		logic        last;
	} dec_result_t;

	dec_result_t expected_results[$];
	dec_result_t byte_results[$];

	dec_state_e  st;
	logic [5:0]  hdr_cnt;
	logic [31:0] field_sr;
	logic [12:0] img_w;
	logic [12:0] img_h;
	logic [5:0]  depth;
	logic [8:0]  pal_cnt;
	logic [8:0]  pal_done;
	logic [12:0] col;
	logic [12:0] row;
	logic [14:0] row_bytes;
	logic [1:0]  sub;
	logic [23:0] colour_acc;

	task automatic clear_state();
		st = ST_HEADER;
		hdr_cnt = '0;
		field_sr = '0;
		img_w = '0;
		img_h = '0;
		depth = '0;
		pal_cnt = '0;
		pal_done = '0;
		col = '0;
		row = '0;
		row_bytes = '0;
		sub = '0;
		colour_acc = '0;
	endtask

	task automatic add_result(logic [2:0] k, logic [12:0] rx, logic [12:0] ry,
			logic [7:0] idx, logic [7:0] r, logic [7:0] g, logic [7:0] b,
			logic [2:0] err, logic done);
		dec_result_t res;
		res = '{k, rx, ry, idx, r, g, b, err, done, 1'b0};
		if (byte_results.size() < 8)
			byte_results.push_back(res);
	endtask

	task automatic raise_error(logic [2:0] code);
		add_result(KIND_ERROR, 0, 0, 0, 0, 0, 0, code, 0);
		st = ST_ERROR;
	endtask

	function automatic int stride_bytes();
		int w;
		int d;
		w = img_w;
		case (depth)
			6'd1: d = (w + 7) / 8;
			6'd4: d = (w + 1) / 2;
			6'd8: d = w;
			6'd24: d = 3 * w;
			default: d = 4 * w;
		endcase
		return (d + 3) & ~3;
	endfunction

	task automatic emit_pixel(logic [2:0] k, logic [7:0] idx, logic [7:0] r,
			logic [7:0] g, logic [7:0] b);
		logic done;
		done = (int'(col) + 1 == int'(img_w)) && (row == 0);
		add_result(k, col, row, idx, r, g, b, 0, done);
		col = col + 1;
		if (done)
			st = ST_DONE;
	endtask

	task automatic header_step(logic [7:0] b);
		int c;
		logic [15:0] d;
		c = hdr_cnt;
		if ((c == 0 && b != SIG_B) || (c == 1 && b != SIG_M)) begin
			raise_error(ERR_SIGNATURE);
			return;
		end
		field_sr = {b, field_sr[31:8]};
		d = field_sr[31:16];
		case (c)
			21: img_w = (field_sr >= 1 && field_sr <= DEF_MAX_WIDTH) ? field_sr[12:0] : '0;
			25: img_h = (field_sr >= 1 && field_sr <= DEF_MAX_HEIGHT) ? field_sr[12:0] : '0;
			29: depth = (d == 1 || d == 4 || d == 8 || d == 24 || d == 32) ? d[5:0] : '0;
			49: pal_cnt = (field_sr > 511) ? 9'd511 : field_sr[8:0];
			default: ;
		endcase
		if (c < 53) begin
			hdr_cnt = hdr_cnt + 1;
			return;
		end
		if (depth == 0) begin
			raise_error(ERR_DEPTH);
			return;
		end
		if (img_w == 0 || img_h == 0) begin
			raise_error(ERR_SIZE);
			return;
		end
		if (depth <= 8) begin
			if (pal_cnt == 0)
				pal_cnt = 9'd1 << depth;
			if (pal_cnt > DEF_MAX_PALETTE) begin
				raise_error(ERR_PALETTE);
				return;
			end
		end else begin
			pal_cnt = '0;
		end
		add_result(KIND_INFO, img_w, img_h, {2'b0, depth}, 0, 0, 0, 0, 0);
		row = img_h - 1;
		st = (pal_cnt != 0) ? ST_PALETTE : ST_PIXELS;
	endtask

	task automatic palette_step(logic [7:0] b);
		if (sub < 3) begin
			colour_acc[8 * sub +: 8] = b;
			sub = sub + 1;
			return;
		end
		sub = 0;
		add_result(KIND_PALETTE, 0, 0, pal_done[7:0], colour_acc[23:16], colour_acc[15:8],
			colour_acc[7:0], 0, 0);
		pal_done = pal_done + 1;
		if (pal_done >= pal_cnt)
			st = ST_PIXELS;
	endtask

	task automatic pixel_step(logic [7:0] b);
		int k;
		if (sub == 3) begin
			sub = 0;
		end else if (col < img_w) begin
			if (depth == 1) begin
				for (k = 7; k >= 0 && col < img_w; k--)
					emit_pixel(KIND_INDEXED, {7'b0, b[k]}, 0, 0, 0);
			end else if (depth == 4) begin
				emit_pixel(KIND_INDEXED, {4'b0, b[7:4]}, 0, 0, 0);
				if (col < img_w)
					emit_pixel(KIND_INDEXED, {4'b0, b[3:0]}, 0, 0, 0);
			end else if (depth == 8) begin
				emit_pixel(KIND_INDEXED, b, 0, 0, 0);
			end else if (sub == 0) begin
				colour_acc = {16'b0, b};
				sub = 1;
			end else if (sub == 1) begin
				colour_acc = {8'b0, b, colour_acc[7:0]};
				sub = 2;
			end else begin
				emit_pixel(KIND_COLOUR, 0, b, colour_acc[15:8], colour_acc[7:0]);
				sub = (depth == 32) ? 2'd3 : 2'd0;
			end
		end
		row_bytes = row_bytes + 1;
		if (int'(row_bytes) >= stride_bytes()) begin
			row_bytes = '0;
			col = '0;
			if (row > 0)
				row = row - 1;
		end
	endtask

	task automatic decode_byte(logic [7:0] b, logic eos);
		byte_results.delete();
		case (st)
			ST_HEADER: header_step(b);
			ST_PALETTE: palette_step(b);
			ST_PIXELS: pixel_step(b);
			default: ;
		endcase
		if (eos) begin
			// truncated stream: drop this byte's results, report only the truncation
			if (st != ST_DONE && st != ST_ERROR) begin
				byte_results.delete();
				add_result(KIND_ERROR, 0, 0, 0, 0, 0, 0, ERR_TRUNCATED, 0);
			end
			clear_state();
		end
		if (byte_results.size() > 0)
			byte_results[byte_results.size() - 1].last = 1'b1;
		foreach (byte_results[i])
			expected_results.push_back(byte_results[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		dec_result_t want;
		dec_result_t got;
		if (!arst_n) begin
			clear_state();
			expected_results.delete();
			mismatches <= 0;
			pending <= 0;
			checked <= 0;
		end else begin
			if (in_valid && in_ready)
				decode_byte(data_byte, end_of_stream);
			if (out_valid && out_ready) begin
				got = '{kind, x, y, index, red, green, blue, error_code, image_done, last};
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result %p", $time, got);
					mismatches <= mismatches + 1;
				end else begin
					want = expected_results.pop_front();
					if (want !== got) begin
						$display("%0t: result mismatch expected %p actual %p", $time, want, got);
						mismatches <= mismatches + 1;
					end
				end
				checked <= checked + 1;
			end
			pending <= expected_results.size();
		end
	end

endmodule

// ===== bench/bmp_stream_decoder_top_test.sv =====
// Stimulus and verdict for the BMP stream decoder bench.
`timescale 1ns / 1ps
module bmp_stream_decoder_top_test;
	import bmpd_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = '0;
	logic        end_of_stream = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  kind;
	logic [12:0] x;
	logic [12:0] y;
	logic [7:0]  index;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [2:0]  error_code;
	logic        image_done;
	logic        last;
	int          mismatches;
	int          pending;
	int          checked;
	int          cyc = 0;
	int          bytes_sent = 0;
	int          files_sent = 0;
	logic        quiet;
	logic [7:0]  file_bytes[$];

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	bmp_stream_decoder_top u_top (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.data_byte(data_byte), .end_of_stream(end_of_stream), .out_valid(out_valid),
		.out_ready(out_ready), .kind(kind), .x(x), .y(y), .index(index), .red(red),
		.green(green), .blue(blue), .error_code(error_code), .image_done(image_done),
		.last(last)
	);

	bmp_decoder_checker u_checker (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.data_byte(data_byte), .end_of_stream(end_of_stream), .out_valid(out_valid),
		.out_ready(out_ready), .kind(kind), .x(x), .y(y), .index(index), .red(red),
		.green(green), .blue(blue), .error_code(error_code), .image_done(image_done),
		.last(last), .mismatches(mismatches), .pending(pending), .checked(checked)
	);

	// no idling on either side through this window
	assign quiet = (cyc >= 150 && cyc < 450);

	always @(posedge clk)
		cyc <= cyc + 1;

	always @(negedge clk)
		out_ready = quiet || ($urandom_range(99) >= 16);

	// drive one transaction and hold it until accepted; valid stays up for the next one
	task automatic send_byte(logic [7:0] b, logic eos);
		logic rdy;
		@(negedge clk);
		while (!quiet && $urandom_range(99) < 16) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		data_byte = b;
		end_of_stream = eos;
		forever begin
			#1 rdy = in_ready;
			@(posedge clk);
			if (rdy)
				break;
			@(negedge clk);
		end
		bytes_sent++;
	endtask

	// drop valid after the last accepted transaction
	task automatic drop_valid();
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic send_file();
		foreach (file_bytes[i])
			send_byte(file_bytes[i], i == file_bytes.size() - 1);
		files_sent++;
	endtask

	task automatic push_word(int unsigned v, int n);
		for (int i = 0; i < n; i++)
			file_bytes.push_back(v[8 * i +: 8]);
	endtask

	// build a file: mode 0 good, 1 bad depth, 2 bad size, 3 oversized palette, 4 truncated
	task automatic build_file(int mode);
		int unsigned w;
		int unsigned h;
		int unsigned d;
		int unsigned pc;
		int unsigned entries;
		int stride;
		int cut;
		int depths[5] = '{1, 4, 8, 24, 32};
		file_bytes.delete();
		w = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(9, 1);
		h = $urandom_range(3, 1);
		d = depths[$urandom_range(4)];
		pc = 0;
		if (d <= 8)
			pc = ($urandom_range(3) == 0) ? 0 : $urandom_range(3, 1);
		if (d == 8 && pc == 0)
			pc = $urandom_range(4, 2);
		if (mode == 1)
			d = ($urandom_range(1) == 0) ? $urandom_range(3) * 2 : $urandom_range(65535);
		if (mode == 2) begin
			case ($urandom_range(3))
				0: w = 0;
				1: h = 0;
				2: w = $urandom_range(5000, 4097);
				default: h = 32'hFFFF_FFFF;
			endcase
		end
		if (mode == 3) begin
			d = 8;
			pc = ($urandom_range(1) == 0) ? 257 : $urandom;
		end
		if (mode == 1 && d inside {1, 4, 8, 24, 32})
			d = 2;
		file_bytes.push_back(SIG_B);
		file_bytes.push_back(SIG_M);
		push_word($urandom, 4);
		push_word($urandom, 4);
		push_word($urandom, 4);
		push_word($urandom, 4);
		push_word(w, 4);
		push_word(h, 4);
		push_word($urandom, 2);
		push_word(d, 2);
		for (int i = 0; i < 16; i++)
			file_bytes.push_back(8'($urandom));
		push_word(pc, 4);
		push_word($urandom, 4);
		if (mode == 0 || mode == 4) begin
			entries = (d > 8) ? 0 : ((pc == 0) ? (1 << d) : pc);
			case (d)
				1: stride = (w + 7) / 8;
				4: stride = (w + 1) / 2;
				8: stride = w;
				24: stride = 3 * w;
				default: stride = 4 * w;
			endcase
			stride = (stride + 3) & ~3;
			for (int i = 0; i < 4 * entries + stride * h; i++)
				file_bytes.push_back(8'($urandom));
			if ($urandom_range(2) == 0)
				for (int i = $urandom_range(3, 1); i > 0; i--)
					file_bytes.push_back(8'($urandom));
		end else begin
			file_bytes.push_back(8'($urandom));
		end
		if (mode == 4) begin
			cut = $urandom_range(file_bytes.size() - 1, 1);
			while (file_bytes.size() > cut)
				void'(file_bytes.pop_back());
		end
	endtask

	initial begin
		int mode;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// signature failures, ignored bytes after an error, and short truncations
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(SIG_B, 1'b1);
		send_byte(SIG_B, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(SIG_B, 1'b1);
		send_byte(SIG_B, 1'b0);
		send_byte(SIG_M, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(SIG_M, 1'b0);
		send_byte(8'h55, 1'b1);

		while (bytes_sent < 400) begin
			mode = $urandom_range(9);
			mode = (mode < 5) ? 0 : mode - 5;
			build_file(mode);
			send_file();
			// hold off once until the decoder has drained
			if (files_sent == 4) begin
				drop_valid();
				while (pending != 0)
					@(negedge clk);
			end
		end

		drop_valid();
		while (pending != 0)
			@(negedge clk);
		repeat (30) @(posedge clk);
		$display("Sent %0d files in %0d bytes; checked %0d results covering all depths,",
			files_sent, bytes_sent, checked);
		$display("palettes, header errors, truncation and trailing bytes.");
		if (mismatches == 0 && pending == 0)
			$display("bmp_stream_decoder_top_test: clean");
		else
			$display("bmp_stream_decoder_top_test: errors");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("Run timed out with %0d results outstanding", pending);
		$display("bmp_stream_decoder_top_test: errors");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/bmpd_pkg.sv
rtl/bmpd_front.sv
rtl/bmpd_queue.sv
rtl/bmpd_back.sv
rtl/bmp_stream_decoder_top.sv
bench/bmp_decoder_checker.sv
bench/bmp_stream_decoder_top_test.sv
